// ===== sv/rlla_pkg.sv =====
// ----------------------------------------------------------------------------
// rlla_pkg
// Types and codes shared by the lag action ladder modules.
// ----------------------------------------------------------------------------
package rlla_pkg;

  // register indexes on the config port
  localparam logic [1:0] REG_FAST_THRESHOLD     = 2'd0;
  localparam logic [1:0] REG_SKIP_THRESHOLD     = 2'd1;
  localparam logic [1:0] REG_SNAPSHOT_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_COOLDOWN_MS        = 2'd3;

  localparam logic [31:0] FAST_THRESHOLD_RESET     = 32'd1;
  localparam logic [31:0] SKIP_THRESHOLD_RESET     = 32'd4;
  localparam logic [31:0] SNAPSHOT_THRESHOLD_RESET = 32'd16;
  localparam logic [31:0] COOLDOWN_MS_RESET        = 32'd1000;

  localparam logic ACT_DECIDE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    DEC_FAST   = 2'd0,
    DEC_SKIP   = 2'd1,
    DEC_SNAP   = 2'd2,
    DEC_RESEED = 2'd3
  } dec_t;

  // class assigned by the front end
  typedef enum logic [2:0] {
    CLS_FAST,
    CLS_SKIP,
    CLS_SNAP,
    CLS_RESEED_REQ,
    CLS_CLEAR
  } cls_t;

  typedef struct packed {
    logic        action;
    logic [31:0] lag_frames;
    logic [47:0] time_ms;
  } item_t;

  typedef struct packed {
    dec_t        decision;
    logic [31:0] skip_count;
    logic [47:0] total_drops;
    logic [31:0] total_reseeds;
    logic [31:0] total_steps;
  } result_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] skip_n;
    logic [47:0] time_ms;
  } job_t;

  typedef struct packed {
    logic [31:0] fast;
    logic [31:0] skip;
    logic [31:0] snapshot;
  } thr_t;

endpackage

// ===== sv/rlla_fifo.sv =====
// ----------------------------------------------------------------------------
// rlla_fifo
// Small register FIFO used between front and back and on the result side.
// ----------------------------------------------------------------------------
module rlla_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== sv/rlla_front.sv =====
// ----------------------------------------------------------------------------
// rlla_front
// Threshold ladder: classifies each item and works out the skip count.
// ----------------------------------------------------------------------------
module rlla_front (
  input  rlla_pkg::item_t item,
  input  rlla_pkg::thr_t  thr,
  output rlla_pkg::job_t  job
);

  always_comb begin
    job.time_ms = item.time_ms;
    job.skip_n  = '0;
    if (item.action == rlla_pkg::ACT_CLEAR) begin
      job.cls = rlla_pkg::CLS_CLEAR;
    end else if (item.lag_frames <= thr.fast) begin
      job.cls = rlla_pkg::CLS_FAST;
    end else if (item.lag_frames <= thr.skip) begin
      job.cls    = rlla_pkg::CLS_SKIP;
      job.skip_n = item.lag_frames - thr.fast;
    end else if (item.lag_frames <= thr.snapshot) begin
      job.cls = rlla_pkg::CLS_SNAP;
    end else begin
      job.cls = rlla_pkg::CLS_RESEED_REQ;
    end
  end

endmodule

// ===== sv/rlla_back.sv =====
// ----------------------------------------------------------------------------
// rlla_back
// Carries out classified jobs: reseed cooldown, counters, result build.
// ----------------------------------------------------------------------------
module rlla_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  rlla_pkg::job_t    job,
  output logic              job_take,
  input  logic              res_full,
  output rlla_pkg::result_t res,
  input  logic [31:0]       cooldown_ms
);

  logic        reseed_seen;
  logic [47:0] last_reseed_time;
  logic [47:0] drop_sum;
  logic [31:0] reseed_tally;
  logic [31:0] step_tally;

  logic        reseed_seen_next;
  logic [47:0] last_reseed_time_next;
  logic [47:0] drop_sum_next;
  logic [31:0] reseed_tally_next;
  logic [31:0] step_tally_next;

  logic [48:0] elapsed;
  logic        cooled;

  assign job_take = job_valid && !res_full;

  // signed 49-bit difference; negative never meets the cooldown
  assign elapsed = {1'b0, job.time_ms} - {1'b0, last_reseed_time};
  assign cooled  = !elapsed[48] && (elapsed[47:0] >= {16'b0, cooldown_ms});

  always_comb begin
    reseed_seen_next      = reseed_seen;
    last_reseed_time_next = last_reseed_time;
    drop_sum_next         = drop_sum;
    reseed_tally_next     = reseed_tally;
    step_tally_next       = step_tally + 32'd1;
    res.decision          = rlla_pkg::DEC_FAST;
    res.skip_count        = '0;
    case (job.cls)
      rlla_pkg::CLS_CLEAR: begin
        reseed_seen_next      = 1'b0;
        last_reseed_time_next = '0;
        drop_sum_next         = '0;
        reseed_tally_next     = '0;
        step_tally_next       = '0;
      end
      rlla_pkg::CLS_FAST: begin
        res.decision = rlla_pkg::DEC_FAST;
      end
      rlla_pkg::CLS_SKIP: begin
        res.decision   = rlla_pkg::DEC_SKIP;
        res.skip_count = job.skip_n;
        drop_sum_next  = drop_sum + {16'b0, job.skip_n};
      end
      rlla_pkg::CLS_SNAP: begin
        res.decision = rlla_pkg::DEC_SNAP;
      end
      rlla_pkg::CLS_RESEED_REQ: begin
        if (!reseed_seen || cooled) begin
          res.decision          = rlla_pkg::DEC_RESEED;
          reseed_seen_next      = 1'b1;
          last_reseed_time_next = job.time_ms;
          reseed_tally_next     = reseed_tally + 32'd1;
        end else begin
          res.decision = rlla_pkg::DEC_SNAP;
        end
      end
      default: begin
        res.decision    = rlla_pkg::DEC_FAST;
        step_tally_next = step_tally;
      end
    endcase
    res.total_drops   = drop_sum_next;
    res.total_reseeds = reseed_tally_next;
    res.total_steps   = step_tally_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reseed_seen      <= 1'b0;
      last_reseed_time <= '0;
      drop_sum         <= '0;
      reseed_tally     <= '0;
      step_tally       <= '0;
    end else if (job_take) begin
      reseed_seen      <= reseed_seen_next;
      last_reseed_time <= last_reseed_time_next;
      drop_sum         <= drop_sum_next;
      reseed_tally     <= reseed_tally_next;
      step_tally       <= step_tally_next;
    end
  end

endmodule

// ===== sv/rate_limited_lag_action_ladder_top.sv =====
// ----------------------------------------------------------------------------
// rate_limited_lag_action_ladder_top
// Lag action ladder with reseed cooldown, queue interfaces on both sides.
// ----------------------------------------------------------------------------
// One item per clock is sustained while results are popped: the front end
// classifies an item in the cycle it is pushed and writes it to a job queue;
// the back end takes one job a cycle while the result queue has room, updates
// the counters and reseed history and writes the result to the result queue.
// A result thus passes through the job queue and then the result queue before
// it shows on the result ports. The block holds up to JOB_DEPTH + RES_DEPTH
// items when results are not popped, after which full rises.
module rate_limited_lag_action_ladder_top #(
  parameter int JOB_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rlla_pkg::item_t   item,
  output logic              full,
  input  logic              pop,
  output rlla_pkg::result_t result,
  output logic              empty,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  rlla_pkg::thr_t    thr;
  logic [31:0]       cooldown_ms;
  rlla_pkg::job_t    job_in;
  rlla_pkg::job_t    job_out;
  logic              job_empty;
  logic              job_take;
  logic              res_full;
  rlla_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.fast     <= rlla_pkg::FAST_THRESHOLD_RESET;
      thr.skip     <= rlla_pkg::SKIP_THRESHOLD_RESET;
      thr.snapshot <= rlla_pkg::SNAPSHOT_THRESHOLD_RESET;
      cooldown_ms  <= rlla_pkg::COOLDOWN_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rlla_pkg::REG_FAST_THRESHOLD:     thr.fast     <= cfg_data;
        rlla_pkg::REG_SKIP_THRESHOLD:     thr.skip     <= cfg_data;
        rlla_pkg::REG_SNAPSHOT_THRESHOLD: thr.snapshot <= cfg_data;
        rlla_pkg::REG_COOLDOWN_MS:        cooldown_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  rlla_front u_front (
    .item (item),
    .thr  (thr),
    .job  (job_in)
  );

  rlla_fifo #(
    .WIDTH ($bits(rlla_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_take),
    .rdata (job_out),
    .empty (job_empty)
  );

  rlla_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (!job_empty),
    .job         (job_out),
    .job_take    (job_take),
    .res_full    (res_full),
    .res         (res),
    .cooldown_ms (cooldown_ms)
  );

  rlla_fifo #(
    .WIDTH ($bits(rlla_pkg::result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_take),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== test/rate_limited_lag_action_ladder_top_tb.sv =====
// ----------------------------------------------------------------------------
// rate_limited_lag_action_ladder_top_tb
// Self-checking bench for the lag action ladder: a directed table at reset
// thresholds, a full-rate burst of maximal skips, then randomized phases under
// several threshold settings, scored against a cycle-free model of the ladder
// or, for pinned directed rows, against the expected results in the table.
// ----------------------------------------------------------------------------
module rate_limited_lag_action_ladder_top_tb;
  import rlla_pkg::*;

  localparam int LATENCY        = 4;
  localparam int RX_HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS    = 110;
  localparam int BURST_ITEMS    = 40;

  typedef struct packed {
    logic    pin;
    result_t want;
  } pinned_t;

  typedef struct packed {
    item_t   it;
    logic    pin;
    result_t want;
  } row_t;

  // reset thresholds: fast 1, skip 4, snapshot 16, cooldown 1000
  localparam row_t DIRECTED [19] = '{
    '{'{ACT_DECIDE, 32'd0, 48'd0}, 1'b1, '{DEC_FAST, 32'd0, 48'd0, 32'd0, 32'd1}},
    '{'{ACT_DECIDE, 32'd1, 48'd5}, 1'b1, '{DEC_FAST, 32'd0, 48'd0, 32'd0, 32'd2}},
    '{'{ACT_DECIDE, 32'd2, 48'd6}, 1'b1, '{DEC_SKIP, 32'd1, 48'd1, 32'd0, 32'd3}},
    '{'{ACT_DECIDE, 32'd4, 48'd7}, 1'b0, '0},
    '{'{ACT_DECIDE, 32'd5, 48'd8}, 1'b0, '0},
    '{'{ACT_DECIDE, 32'd16, 48'd9}, 1'b0, '0},
    '{'{ACT_DECIDE, 32'd17, 48'd100}, 1'b0, '0},                 // first reseed
    '{'{ACT_DECIDE, 32'hFFFF_FFFF, 48'd500}, 1'b0, '0},          // cooling down
    '{'{ACT_DECIDE, 32'd1000, 48'd1099}, 1'b0, '0},              // one ms short
    '{'{ACT_DECIDE, 32'd20, 48'd1100}, 1'b0, '0},                // exactly met
    '{'{ACT_DECIDE, 32'd20, 48'd50}, 1'b0, '0},                  // time went back
    '{'{ACT_DECIDE, 32'd20, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
    '{'{ACT_DECIDE, 32'd20, 48'd0}, 1'b0, '0},
    '{'{ACT_CLEAR, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1'b1, '0},
    '{'{ACT_DECIDE, 32'd20, 48'd0}, 1'b1, '{DEC_RESEED, 32'd0, 48'd0, 32'd1, 32'd1}},
    '{'{ACT_DECIDE, 32'd3, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
    '{'{ACT_CLEAR, 32'd0, 48'd0}, 1'b1, '0},
    '{'{ACT_DECIDE, 32'hAAAA_AAAA, 48'h5555_5555_5555}, 1'b0, '0},
    '{'{ACT_DECIDE, 32'h5555_5555, 48'hAAAA_AAAA_AAAA}, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  item_t       item = '0;
  logic        full;
  logic        pop = 1'b0;
  result_t     result;
  logic        empty;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_FAST_THRESHOLD;
  logic [31:0] cfg_data = '0;

  rate_limited_lag_action_ladder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ladder model state
  logic [31:0] thr_fast, thr_skip, thr_snap, thr_cool;
  logic        reseed_granted;
  logic [47:0] last_grant_ms;
  logic [47:0] drop_acc;
  logic [31:0] reseed_cnt, step_cnt;

  result_t     outcome_q[$];
  pinned_t     pinned_q[$];
  int          mismatches = 0;

  // stimulus side
  int          tx_idle_pct = 38;
  int          rx_idle_pct = 38;
  bit          rx_hold_req = 1'b0;
  logic [31:0] stim_fast = FAST_THRESHOLD_RESET;
  logic [31:0] stim_skip = SKIP_THRESHOLD_RESET;
  logic [31:0] stim_snap = SNAPSHOT_THRESHOLD_RESET;
  logic [47:0] now_ms = 48'd2000;

  function automatic void wipe_history();
    reseed_granted = 1'b0;
    last_grant_ms  = '0;
    drop_acc       = '0;
    reseed_cnt     = '0;
    step_cnt       = '0;
  endfunction

  function automatic result_t ladder_step(input item_t it);
    result_t r;
    longint  elapsed;
    r = '0;
    r.decision = DEC_FAST;
    if (it.action == ACT_CLEAR) begin
      wipe_history();
    end else begin
      step_cnt = step_cnt + 32'd1;
      if (it.lag_frames <= thr_fast) begin
        r.decision = DEC_FAST;
      end else if (it.lag_frames <= thr_skip) begin
        r.decision   = DEC_SKIP;
        r.skip_count = it.lag_frames - thr_fast;
        drop_acc     = drop_acc + {16'b0, r.skip_count};
      end else if (it.lag_frames <= thr_snap) begin
        r.decision = DEC_SNAP;
      end else begin
        // signed difference, so a clock that went backwards never qualifies
        elapsed = longint'({16'b0, it.time_ms}) - longint'({16'b0, last_grant_ms});
        if (!reseed_granted || elapsed >= longint'({32'b0, thr_cool})) begin
          reseed_granted = 1'b1;
          last_grant_ms  = it.time_ms;
          reseed_cnt     = reseed_cnt + 32'd1;
          r.decision     = DEC_RESEED;
        end else begin
          r.decision = DEC_SNAP;
        end
      end
    end
    r.total_drops   = drop_acc;
    r.total_reseeds = reseed_cnt;
    r.total_steps   = step_cnt;
    return r;
  endfunction

  function automatic void compare_field(string fld, logic [47:0] w, logic [47:0] g);
    if (w !== g) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, w, g);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t want;
    pinned_t pinned;
    if (rst) begin
      thr_fast = FAST_THRESHOLD_RESET;
      thr_skip = SKIP_THRESHOLD_RESET;
      thr_snap = SNAPSHOT_THRESHOLD_RESET;
      thr_cool = COOLDOWN_MS_RESET;
      wipe_history();
    end else begin
      if (pop && !empty) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %h", $time, result);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("decision", want.decision, result.decision);
          compare_field("skip_count", want.skip_count, result.skip_count);
          compare_field("total_drops", want.total_drops, result.total_drops);
          compare_field("total_reseeds", want.total_reseeds, result.total_reseeds);
          compare_field("total_steps", want.total_steps, result.total_steps);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FAST_THRESHOLD:     thr_fast = cfg_data;
          REG_SKIP_THRESHOLD:     thr_skip = cfg_data;
          REG_SNAPSHOT_THRESHOLD: thr_snap = cfg_data;
          REG_COOLDOWN_MS:        thr_cool = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        pinned = pinned_q.pop_front();
        want   = ladder_step(item);
        outcome_q.push_back(pinned.pin ? pinned.want : want);
      end
    end
  end

  // result side: random pop, with an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send(input item_t it, input logic pin, input result_t want);
    pinned_q.push_back('{pin, want});
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
  endtask

  // stop offering and let every outstanding transfer come back
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] f, s, n, c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FAST_THRESHOLD;
    cfg_data  <= f;
    @(posedge clk);
    cfg_index <= REG_SKIP_THRESHOLD;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= REG_SNAPSHOT_THRESHOLD;
    cfg_data  <= n;
    @(posedge clk);
    cfg_index <= REG_COOLDOWN_MS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stim_fast = f;
    stim_skip = s;
    stim_snap = n;
  endtask

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t       it;
    logic [63:0] wide;
    int          sel;
    wide = {$urandom, $urandom};
    it.action = ($urandom_range(99) < 3) ? ACT_CLEAR : ACT_DECIDE;
    case ($urandom_range(9))
      0:       it.lag_frames = '0;
      1:       it.lag_frames = '1;
      2:       it.lag_frames = stim_fast + $urandom_range(2) - 1;
      3:       it.lag_frames = stim_skip + $urandom_range(2) - 1;
      4:       it.lag_frames = stim_fast + $urandom_range(1, 3);
      5:       it.lag_frames = stim_snap + $urandom_range(2) - 1;
      6:       it.lag_frames = $urandom;
      default: it.lag_frames = stim_snap + $urandom_range(1, 8);
    endcase
    // clock mostly creeps forward; sometimes jumps anywhere or looks back
    sel = $urandom_range(19);
    if (sel == 0)
      now_ms = wide[47:0];
    else if (sel != 1)
      now_ms = now_ms + $urandom_range(0, 600);
    it.time_ms = (sel == 1) ? now_ms - $urandom_range(1, 3000) : now_ms;
    return it;
  endfunction

  initial begin
    logic [31:0] f, s, n, c;
    item_t       burst_item;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      send(DIRECTED[i].it, DIRECTED[i].pin, DIRECTED[i].want);
    end
    wait_idle();

    // full-rate burst of maximal skips, drop total climbs by 2^32-1 each item
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs('0, '1, '1, COOLDOWN_MS_RESET);
    burst_item = '{ACT_DECIDE, 32'hFFFF_FFFF, 48'd0};
    repeat (BURST_ITEMS) send(burst_item, 1'b0, '0);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      tx_idle_pct = 38;
      rx_idle_pct = 38;
      f = $urandom_range(0, 8);
      s = f + $urandom_range(0, 10);
      n = s + $urandom_range(0, 20);
      c = $urandom_range(0, 1500);
      case (p)
        0: set_regs(FAST_THRESHOLD_RESET, SKIP_THRESHOLD_RESET,
                    SNAPSHOT_THRESHOLD_RESET, COOLDOWN_MS_RESET);
        1: set_regs('1, '1, '1, '1);
        2: set_regs('0, '0, '0, '0);
        3: begin
          // skip band empty; receiver stalls while items keep coming
          set_regs(32'd10, 32'd3, 32'd40, 32'd300);
          tx_idle_pct = 0;
          rx_hold_req = 1'b1;
        end
        4: begin
          set_regs(f, s, n, c);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        5, 7: set_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg());
        8: set_regs(f, s, n, '1);
        default: set_regs(f, s, n, c);
      endcase
      repeat (PHASE_ITEMS) send(rand_item(), 1'b0, '0);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rlla_pkg.sv
sv/rlla_fifo.sv
sv/rlla_front.sv
sv/rlla_back.sv
sv/rate_limited_lag_action_ladder_top.sv
test/rate_limited_lag_action_ladder_top_tb.sv
